@@ rtl/diff_drive_odometry_unit_assert.svh @@
// Assertion macros used by the odometry sequencer.
`ifndef DIFF_DRIVE_ODOMETRY_UNIT_ASSERT_SVH
`define DIFF_DRIVE_ODOMETRY_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define DDO_CHECK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("odometry check failed");
`define DDO_CHECK_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("odometry check failed");
`else
`define DDO_CHECK(lbl, clk, rstn, prop)
`define DDO_CHECK_ALWAYS(lbl, clk, prop)
`endif
`endif

@@ rtl/ddo_pkg.sv @@
// Types, constants and tables for the differential drive odometry block.
`default_nettype none
package ddo_pkg;

  localparam int RAD_W   = 16;
  localparam int SEP_W   = 20;
  localparam int DIV_W   = 50;
  localparam int CORD_W  = 34;
  localparam int MUL_A_W = 35;
  localparam int MUL_B_W = 34;
  localparam int CORDIC_STEPS_DEF = 16;

  localparam logic [RAD_W-1:0] RADIUS_RST = 16'd4915;
  localparam logic [SEP_W-1:0] SEP_RST    = 20'd32768;
  localparam logic [29:0]      TURN_K     = 30'd683565276;
  localparam logic [31:0]      GAIN_Q30   = 32'd652032874;

  localparam logic [2:0] ADDR_RADIUS = 3'd0;
  localparam logic [2:0] ADDR_SEP    = 3'd4;

  typedef struct packed {
    logic signed [15:0] left_rate;
    logic signed [15:0] right_rate;
    logic [15:0]        elapsed_time;
  } in_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [15:0]        heading_out;
    logic [30:0]        linear_speed;
    logic signed [31:0] angular_rate;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
  } out_t;

  typedef enum logic [4:0] {
    DP_NOP,
    DP_LOAD,
    DP_MUL_VL,
    DP_MUL_VR,
    DP_MUL_SL,
    DP_MUL_SR,
    DP_DIVQ_START,
    DP_DIVQ_TAKE,
    DP_MUL_PLO,
    DP_MUL_PHI,
    DP_CORDIC_INIT,
    DP_CORDIC_STEP,
    DP_DIVW_TAKE,
    DP_MUL_DX,
    DP_MUL_DY,
    DP_MUL_VX,
    DP_MUL_VY,
    DP_COMMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic cordic_done;
  } dp_status_t;

  function automatic logic [31:0] atan_ent(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

@@ rtl/ddo_div.sv @@
// Unsigned restoring divider, two quotient bits per cycle.
`default_nettype none
module ddo_div (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [ddo_pkg::DIV_W-1:0] dividend,
  input  wire logic [ddo_pkg::SEP_W-1:0] divisor,
  output logic [ddo_pkg::DIV_W-1:0]      quotient,
  output logic                           done
);
  localparam int ITER = ddo_pkg::DIV_W / 2;
  localparam int CW   = $clog2(ITER);

  logic [ddo_pkg::DIV_W-1:0] dq_r, dq_nxt;
  logic [ddo_pkg::SEP_W-1:0] rem_r, rem_nxt, dvs_r;
  logic [CW-1:0]             cnt_r;
  logic                      busy_r, done_r;

  always_comb begin
    logic [ddo_pkg::SEP_W:0] t;
    rem_nxt = rem_r;
    dq_nxt  = dq_r;
    for (int k = 0; k < 2; k++) begin
      t      = {rem_nxt, dq_nxt[ddo_pkg::DIV_W-1]};
      dq_nxt = {dq_nxt[ddo_pkg::DIV_W-2:0], 1'b0};
      if (t >= {1'b0, dvs_r}) begin
        rem_nxt   = ddo_pkg::SEP_W'(t - {1'b0, dvs_r});
        dq_nxt[0] = 1'b1;
      end else begin
        rem_nxt = t[ddo_pkg::SEP_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CW'(ITER - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dq_r  <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      dq_r  <= dq_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quotient = dq_r;
  assign done     = done_r;
endmodule
`default_nettype wire

@@ rtl/ddo_dp.sv @@
// Odometry datapath: shared multiplier, divider, CORDIC and pose registers.
`default_nettype none
module ddo_dp #(
  parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire ddo_pkg::dp_cmd_t          cmd,
  output ddo_pkg::dp_status_t            status,
  input  wire ddo_pkg::in_t              in_data,
  input  wire logic [ddo_pkg::RAD_W-1:0] radius,
  input  wire logic [ddo_pkg::SEP_W-1:0] separation,
  output ddo_pkg::out_t                  out_data
);
  localparam int CW = $clog2(CORDIC_STEPS + 1);

  ddo_pkg::in_t  in_r;
  ddo_pkg::out_t out_r;

  logic signed [32:0] vl_r, vr_r, m_r;
  logic signed [48:0] sl_r, sr_r;
  logic signed [33:0] vsum_r;
  logic signed [49:0] q_r, wq_r;
  logic [54:0]        plo_r;
  logic [31:0]        phi_r;
  logic               q_neg_r, w_neg_r, flip_r;
  logic [15:0]        hdelta_r;
  logic signed [ddo_pkg::CORD_W-1:0] cx_r, cy_r, cz_r;
  logic [CW-1:0]      cnt_r;
  logic signed [30:0] dx_r, dy_r;
  logic signed [29:0] vx_r, vy_r;
  logic signed [31:0] x_r, y_r, x_nxt, y_nxt;
  logic [15:0]        heading_r, heading_nxt;

  logic signed [ddo_pkg::MUL_A_W-1:0] opa;
  logic signed [ddo_pkg::MUL_B_W-1:0] opb;
  logic signed [68:0] prod;

  logic [ddo_pkg::SEP_W-1:0] divisor;
  logic [ddo_pkg::DIV_W-1:0] div_in, div_q;
  logic div_start, div_done;
  logic signed [49:0] qdiff, wdiv, qmag, wmag;
  logic signed [33:0] vdiff;
  logic [56:0] p57;
  logic [31:0] mid, fold;
  logic signed [ddo_pkg::CORD_W-1:0] xs, ys, atan;
  logic [33:0] vabs;
  logic signed [31:0] w_sat;

  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v[32] != v[31]) r = v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    else r = v[31:0];
    return r;
  endfunction

  // shared multiplier
  always_comb begin
    opa = '0;
    opb = '0;
    unique case (cmd.op)
      ddo_pkg::DP_MUL_VL: begin
        opa = ddo_pkg::MUL_A_W'(in_r.left_rate);
        opb = ddo_pkg::MUL_B_W'(radius);
      end
      ddo_pkg::DP_MUL_VR: begin
        opa = ddo_pkg::MUL_A_W'(in_r.right_rate);
        opb = ddo_pkg::MUL_B_W'(radius);
      end
      ddo_pkg::DP_MUL_SL: begin
        opa = ddo_pkg::MUL_A_W'(vl_r);
        opb = ddo_pkg::MUL_B_W'(in_r.elapsed_time);
      end
      ddo_pkg::DP_MUL_SR: begin
        opa = ddo_pkg::MUL_A_W'(vr_r);
        opb = ddo_pkg::MUL_B_W'(in_r.elapsed_time);
      end
      ddo_pkg::DP_MUL_PLO: begin
        opa = ddo_pkg::MUL_A_W'(q_r[24:0]);
        opb = ddo_pkg::MUL_B_W'(ddo_pkg::TURN_K);
      end
      ddo_pkg::DP_MUL_PHI: begin
        opa = ddo_pkg::MUL_A_W'($signed(q_r[49:25]));
        opb = ddo_pkg::MUL_B_W'(ddo_pkg::TURN_K);
      end
      ddo_pkg::DP_MUL_DX: begin
        opa = ddo_pkg::MUL_A_W'(m_r);
        opb = cx_r;
      end
      ddo_pkg::DP_MUL_DY: begin
        opa = ddo_pkg::MUL_A_W'(m_r);
        opb = cy_r;
      end
      ddo_pkg::DP_MUL_VX: begin
        opa = ddo_pkg::MUL_A_W'(vsum_r);
        opb = cx_r;
      end
      ddo_pkg::DP_MUL_VY: begin
        opa = ddo_pkg::MUL_A_W'(vsum_r);
        opb = cy_r;
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
    prod = 69'(opa) * 69'(opb);
  end

  // divider operands
  always_comb begin
    qdiff   = 50'(sl_r) - 50'(sr_r);
    qmag    = qdiff[49] ? -qdiff : qdiff;
    vdiff   = 34'(vl_r) - 34'(vr_r);
    wdiv    = {{8{vdiff[33]}}, vdiff, 8'b0};
    wmag    = wdiv[49] ? -wdiv : wdiv;
    divisor = (separation == '0) ? ddo_pkg::SEP_W'(1) : separation;
    div_start = (cmd.op == ddo_pkg::DP_DIVQ_START) || (cmd.op == ddo_pkg::DP_CORDIC_INIT);
    div_in  = (cmd.op == ddo_pkg::DP_DIVQ_START) ? qmag : wmag;
  end

  ddo_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_in),
    .divisor  (divisor),
    .quotient (div_q),
    .done     (div_done)
  );

  // midpoint angle, fold into the right half plane, CORDIC shifts and angle
  always_comb begin
    p57  = 57'(plo_r) + {phi_r, 25'b0};
    mid  = {heading_r, 16'b0} + p57[56:25];
    fold = mid + 32'h4000_0000;
    xs   = cy_r >>> cnt_r;
    ys   = cx_r >>> cnt_r;
    atan = ddo_pkg::CORD_W'(ddo_pkg::atan_ent(5'(cnt_r)));
  end

  always_comb begin
    logic signed [49:0] wq;
    wq          = wq_r;
    x_nxt       = sat33(33'(x_r) + 33'(dx_r));
    y_nxt       = sat33(33'(y_r) + 33'(dy_r));
    heading_nxt = heading_r + hdelta_r;
    vabs        = vsum_r[33] ? 34'(-vsum_r) : 34'(vsum_r);
    if (wq[49:31] != {19{wq[49]}}) w_sat = wq[49] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    else w_sat = wq[31:0];
  end

  // pose state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r       <= '0;
      y_r       <= '0;
      heading_r <= '0;
      cnt_r     <= '0;
    end else begin
      if (cmd.op == ddo_pkg::DP_COMMIT) begin
        x_r       <= x_nxt;
        y_r       <= y_nxt;
        heading_r <= heading_nxt;
      end
      if (cmd.op == ddo_pkg::DP_CORDIC_INIT) cnt_r <= '0;
      else if (cmd.op == ddo_pkg::DP_CORDIC_STEP) cnt_r <= cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      ddo_pkg::DP_LOAD:   in_r <= in_data;
      ddo_pkg::DP_MUL_VL: vl_r <= prod[32:0];
      ddo_pkg::DP_MUL_VR: vr_r <= prod[32:0];
      ddo_pkg::DP_MUL_SL: sl_r <= prod[48:0];
      ddo_pkg::DP_MUL_SR: sr_r <= prod[48:0];
      ddo_pkg::DP_DIVQ_START: begin
        q_neg_r <= qdiff[49];
        m_r     <= 33'((50'(sl_r) + 50'(sr_r)) >>> 17);
        vsum_r  <= 34'(vl_r) + 34'(vr_r);
      end
      ddo_pkg::DP_DIVQ_TAKE: q_r <= q_neg_r ? -$signed(div_q) : $signed(div_q);
      ddo_pkg::DP_MUL_PLO:   plo_r <= prod[54:0];
      ddo_pkg::DP_MUL_PHI:   phi_r <= prod[31:0];
      ddo_pkg::DP_CORDIC_INIT: begin
        w_neg_r  <= wdiv[49];
        hdelta_r <= p57[55:40];
        flip_r   <= fold[31];
        cz_r     <= ddo_pkg::CORD_W'($signed(fold[31] ? {~mid[31], mid[30:0]} : mid));
        cx_r     <= ddo_pkg::CORD_W'(ddo_pkg::GAIN_Q30);
        cy_r     <= '0;
      end
      ddo_pkg::DP_CORDIC_STEP: begin
        if (!cz_r[ddo_pkg::CORD_W-1]) begin
          cx_r <= cx_r - xs;
          cy_r <= cy_r + ys;
          cz_r <= cz_r - atan;
        end else begin
          cx_r <= cx_r + xs;
          cy_r <= cy_r - ys;
          cz_r <= cz_r + atan;
        end
      end
      ddo_pkg::DP_DIVW_TAKE: begin
        wq_r <= w_neg_r ? -$signed(div_q) : $signed(div_q);
        // undo the half-turn fold
        if (flip_r) begin
          cx_r <= -cx_r;
          cy_r <= -cy_r;
        end
      end
      ddo_pkg::DP_MUL_DX: dx_r <= prod[68:38];
      ddo_pkg::DP_MUL_DY: dy_r <= prod[68:38];
      ddo_pkg::DP_MUL_VX: vx_r <= prod[68:39];
      ddo_pkg::DP_MUL_VY: vy_r <= prod[68:39];
      ddo_pkg::DP_COMMIT: begin
        out_r.pos_x        <= x_nxt;
        out_r.pos_y        <= y_nxt;
        out_r.heading_out  <= heading_nxt;
        out_r.linear_speed <= 31'(vabs[33:9]);
        out_r.angular_rate <= w_sat;
        out_r.vel_x        <= 32'(vx_r);
        out_r.vel_y        <= 32'(vy_r);
      end
      default: ;
    endcase
  end

  assign status.div_done    = div_done;
  assign status.cordic_done = (cnt_r == CW'(CORDIC_STEPS));
  assign out_data           = out_r;
endmodule
`default_nettype wire

@@ rtl/ddo_ctrl.sv @@
// Odometry sequencer: steps the datapath through one transaction at a time.
`default_nettype none
`include "diff_drive_odometry_unit_assert.svh"
module ddo_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output ddo_pkg::dp_cmd_t         cmd,
  input  wire ddo_pkg::dp_status_t status
);
  typedef enum logic [4:0] {
    S_IDLE, S_VL, S_VR, S_SL, S_SR, S_DQ_START, S_DQ_WAIT, S_PLO, S_PHI,
    S_CINIT, S_CSTEP, S_DW_WAIT, S_DX, S_DY, S_VX, S_VY, S_COMMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, slot_free;

  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    cmd.op    = ddo_pkg::DP_NOP;
    unique case (state_r)
      S_IDLE: if (in_valid) begin
        cmd.op    = ddo_pkg::DP_LOAD;
        state_nxt = S_VL;
      end
      S_VL: begin cmd.op = ddo_pkg::DP_MUL_VL; state_nxt = S_VR; end
      S_VR: begin cmd.op = ddo_pkg::DP_MUL_VR; state_nxt = S_SL; end
      S_SL: begin cmd.op = ddo_pkg::DP_MUL_SL; state_nxt = S_SR; end
      S_SR: begin cmd.op = ddo_pkg::DP_MUL_SR; state_nxt = S_DQ_START; end
      S_DQ_START: begin cmd.op = ddo_pkg::DP_DIVQ_START; state_nxt = S_DQ_WAIT; end
      S_DQ_WAIT: if (status.div_done) begin
        cmd.op    = ddo_pkg::DP_DIVQ_TAKE;
        state_nxt = S_PLO;
      end
      S_PLO: begin cmd.op = ddo_pkg::DP_MUL_PLO; state_nxt = S_PHI; end
      S_PHI: begin cmd.op = ddo_pkg::DP_MUL_PHI; state_nxt = S_CINIT; end
      S_CINIT: begin cmd.op = ddo_pkg::DP_CORDIC_INIT; state_nxt = S_CSTEP; end
      S_CSTEP: begin
        if (status.cordic_done) state_nxt = S_DW_WAIT;
        else cmd.op = ddo_pkg::DP_CORDIC_STEP;
      end
      S_DW_WAIT: if (status.div_done) begin
        cmd.op    = ddo_pkg::DP_DIVW_TAKE;
        state_nxt = S_DX;
      end
      S_DX: begin cmd.op = ddo_pkg::DP_MUL_DX; state_nxt = S_DY; end
      S_DY: begin cmd.op = ddo_pkg::DP_MUL_DY; state_nxt = S_VX; end
      S_VX: begin cmd.op = ddo_pkg::DP_MUL_VX; state_nxt = S_VY; end
      S_VY: begin cmd.op = ddo_pkg::DP_MUL_VY; state_nxt = S_COMMIT; end
      S_COMMIT: if (slot_free) begin
        cmd.op    = ddo_pkg::DP_COMMIT;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.op == ddo_pkg::DP_COMMIT) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  `DDO_CHECK(a_commit_free, clk, rst_n,
    (cmd.op == ddo_pkg::DP_COMMIT) |-> (!out_valid_r || !out_stall))
  `DDO_CHECK(a_take_done, clk, rst_n,
    (cmd.op == ddo_pkg::DP_DIVQ_TAKE || cmd.op == ddo_pkg::DP_DIVW_TAKE) |-> status.div_done)
  `DDO_CHECK(a_step_live, clk, rst_n,
    (cmd.op == ddo_pkg::DP_CORDIC_STEP) |-> !status.cordic_done)
  `DDO_CHECK(a_valid_after_commit, clk, rst_n,
    (cmd.op == ddo_pkg::DP_COMMIT) |=> out_valid_r)
endmodule
`default_nettype wire

@@ rtl/diff_drive_odometry_unit.sv @@
// For CORDIC_STEPS up to 24, the time from an accepted transaction until
// out_valid rises is set by the two divider passes (heading change, then
// angular rate, the second overlapped with the CORDIC rotations).
// One transaction at a time; the result register lets the next
// transaction start while a result waits.
// Reset clears pose, heading and control; registers return to their defaults.
`default_nettype none
module diff_drive_odometry_unit #(
  parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire ddo_pkg::in_t in_data,
  output logic              out_valid,
  input  wire logic         out_stall,
  output ddo_pkg::out_t     out_data,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  logic [ddo_pkg::RAD_W-1:0] radius_r;
  logic [ddo_pkg::SEP_W-1:0] sep_r;
  logic                      wr_en;
  ddo_pkg::dp_cmd_t          cmd;
  ddo_pkg::dp_status_t       status;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // decode on the word address bit only
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= ddo_pkg::RADIUS_RST;
      sep_r    <= ddo_pkg::SEP_RST;
    end else if (wr_en) begin
      if (paddr[2] == ddo_pkg::ADDR_SEP[2]) sep_r <= pwdata[ddo_pkg::SEP_W-1:0];
      else radius_r <= pwdata[ddo_pkg::RAD_W-1:0];
    end
  end

  assign prdata = (paddr[2] == ddo_pkg::ADDR_RADIUS[2]) ? 32'(radius_r) : 32'(sep_r);

  ddo_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  ddo_dp #(.CORDIC_STEPS(CORDIC_STEPS)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .in_data    (in_data),
    .radius     (radius_r),
    .separation (sep_r),
    .out_data   (out_data)
  );
endmodule
`default_nettype wire

@@ tb/diff_drive_odometry_unit_tb.sv @@
// Self-checking testbench for the differential drive odometry unit.
`timescale 1ns / 100ps
`default_nettype none
module diff_drive_odometry_unit_tb;

  localparam int STEPS = ddo_pkg::CORDIC_STEPS_DEF;
  localparam int RANDOM_ITEMS = 830;
  localparam logic [31:0] ANGLE_TAB [24] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef struct {
    logic signed [15:0] lr;
    logic signed [15:0] rr;
    logic [15:0]        dt;
    bit                 typed;
    ddo_pkg::out_t      pose;
  } pose_row_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_stall;
  ddo_pkg::in_t  in_data = '0;
  logic          out_valid;
  logic          out_stall = 1'b1;
  ddo_pkg::out_t out_data;
  logic          psel = 1'b0;
  logic          penable = 1'b0;
  logic          pwrite = 1'b0;
  logic [2:0]    paddr = '0;
  logic [31:0]   pwdata = '0;
  logic [31:0]   prdata;
  logic          pready;

  // predictor state
  logic [15:0]        radius_q = ddo_pkg::RADIUS_RST;
  logic [19:0]        sep_q = ddo_pkg::SEP_RST;
  logic signed [31:0] x_q = '0;
  logic signed [31:0] y_q = '0;
  logic [15:0]        heading_q = '0;

  ddo_pkg::out_t pending_poses[$];
  int   error_count = 0;
  bit   idle_mode = 1'b1;

  diff_drive_odometry_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #1500000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Rotate the gain vector to the given binary angle; results in Q30.
  task automatic rotate_angle(input logic [31:0] ang, output longint c, output longint s);
    logic [31:0] a;
    bit          flip;
    longint      xv, yv, z, xs, ys;
    a = ang;
    flip = ((a + 32'h40000000) & 32'h80000000) != 0;
    if (flip) a = a + 32'h80000000;
    z = longint'($signed(a));
    xv = longint'(ddo_pkg::GAIN_Q30);
    yv = 0;
    for (int i = 0; i < STEPS && i < 24; i++) begin
      xs = yv >>> i;
      ys = xv >>> i;
      if (z >= 0) begin
        xv = xv - xs; yv = yv + ys; z = z - longint'(ANGLE_TAB[i]);
      end else begin
        xv = xv + xs; yv = yv - ys; z = z + longint'(ANGLE_TAB[i]);
      end
    end
    if (flip) begin
      xv = -xv; yv = -yv;
    end
    c = xv;
    s = yv;
  endtask

  task automatic advance_pose(input ddo_pkg::in_t d, output ddo_pkg::out_t r);
    longint      b, vl, vr, sl, sr, q, c, s, m, vsum, lin;
    logic [63:0] p;
    logic [31:0] mid;
    b = (sep_q == 0) ? 1 : longint'(sep_q);
    vl = longint'(d.left_rate) * longint'(radius_q);
    vr = longint'(d.right_rate) * longint'(radius_q);
    sl = vl * longint'(d.elapsed_time);
    sr = vr * longint'(d.elapsed_time);
    q = (sl - sr) / b;
    p = q * 64'd683565276;
    mid = {heading_q, 16'h0000} + p[56:25];
    rotate_angle(mid, c, s);
    m = (sl + sr) >>> 17;
    x_q = 32'(clamp32(longint'(x_q) + ((m * c) >>> 38)));
    y_q = 32'(clamp32(longint'(y_q) + ((m * s) >>> 38)));
    heading_q = heading_q + p[55:40];
    vsum = vl + vr;
    lin = (vsum < 0 ? -vsum : vsum) >>> 9;
    r.pos_x = x_q;
    r.pos_y = y_q;
    r.heading_out = heading_q;
    r.linear_speed = lin[30:0];
    r.angular_rate = 32'(clamp32(((vl - vr) * 256) / b));
    r.vel_x = 32'(clamp32((vsum * c) >>> 39));
    r.vel_y = 32'(clamp32((vsum * s) >>> 39));
  endtask

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Called right after a rising edge; returns right after the accepting edge.
  task automatic send_move(input ddo_pkg::in_t d, input bit typed,
                           input ddo_pkg::out_t typed_pose);
    int            gap;
    ddo_pkg::out_t r;
    gap = idle_mode ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= d;
    do @(posedge clk); while (in_stall);
    advance_pose(d, r);
    if (typed) r = typed_pose;
    pending_poses = {pending_poses, r};
  endtask

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ddo_pkg::ADDR_RADIUS) radius_q = data[15:0];
    if (addr == ddo_pkg::ADDR_SEP) sep_q = data[19:0];
  endtask

  // Drain all outstanding transactions before touching the registers.
  task automatic set_geometry(input logic [15:0] rad, input logic [19:0] sep);
    in_valid <= 1'b0;
    while (pending_poses.size() != 0) @(posedge clk);
    repeat (70) @(posedge clk);
    reg_write(ddo_pkg::ADDR_RADIUS, {16'h0, rad});
    reg_write(ddo_pkg::ADDR_SEP, {12'h0, sep});
  endtask

  // result side
  initial begin
    int            n;
    ddo_pkg::out_t want;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      n = idle_mode ? $urandom_range(0, 8) : 0;
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      if (pending_poses.size() == 0) begin
        report("unexpected transaction", 0, 0);
      end else begin
        want = pending_poses.pop_front();
        if (out_data.pos_x !== want.pos_x) report("pos_x", out_data.pos_x, want.pos_x);
        if (out_data.pos_y !== want.pos_y) report("pos_y", out_data.pos_y, want.pos_y);
        if (out_data.heading_out !== want.heading_out)
          report("heading_out", out_data.heading_out, want.heading_out);
        if (out_data.linear_speed !== want.linear_speed)
          report("linear_speed", out_data.linear_speed, want.linear_speed);
        if (out_data.angular_rate !== want.angular_rate)
          report("angular_rate", out_data.angular_rate, want.angular_rate);
        if (out_data.vel_x !== want.vel_x) report("vel_x", out_data.vel_x, want.vel_x);
        if (out_data.vel_y !== want.vel_y) report("vel_y", out_data.vel_y, want.vel_y);
      end
    end
  end

  // stimulus
  initial begin
    pose_row_t    rows[$];
    pose_row_t    row;
    ddo_pkg::in_t d;
    int           pick;
    rows = '{
      '{16'sd0, 16'sd0, 16'd0, 1'b1, '0},
      '{16'sd0, 16'sd0, 16'd65535, 1'b1, '0},
      '{16'sd256, 16'sd256, 16'd0, 1'b0, '0},
      '{16'sd256, 16'sd256, 16'd65535, 1'b0, '0},
      '{16'sd32767, 16'sd32767, 16'd1, 1'b0, '0},
      '{-16'sd32768, -16'sd32768, 16'd1, 1'b0, '0},
      '{16'sd32767, -16'sd32768, 16'd65535, 1'b0, '0},
      '{-16'sd32768, 16'sd32767, 16'd65535, 1'b0, '0},
      '{16'sd512, -16'sd512, 16'd40000, 1'b0, '0},
      '{-16'sd1, 16'sd1, 16'd65535, 1'b0, '0},
      '{16'sd32767, 16'sd32767, 16'd65535, 1'b0, '0},
      '{16'sd32767, 16'sd32767, 16'd65535, 1'b0, '0}
    };
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      row = rows[i];
      send_move('{row.lr, row.rr, row.dt}, row.typed, row.pose);
    end
    // extreme geometry: smallest separation, largest radius, saturates quickly
    set_geometry(16'hFFFF, 20'd1);
    foreach (rows[i]) begin
      row = rows[i];
      send_move('{row.lr, row.rr, row.dt}, 1'b0, '0);
    end
    // zero radius and zero separation
    set_geometry(16'd0, 20'd0);
    for (int i = 0; i < 4; i++) send_move('{row.lr, -row.rr, 16'(i * 20000)}, 1'b0, '0);

    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k % 100 == 0) begin
        pick = $urandom_range(0, 3);
        idle_mode = (pick != 0);
        unique case (pick)
          0: set_geometry(16'd1, 20'hFFFFF);
          1: set_geometry(16'hFFFF, 20'(1 + $urandom_range(0, 255)));
          default: set_geometry(16'($urandom_range(1, 65535)),
                                20'($urandom_range(1, 1048575)));
        endcase
      end
      d.left_rate = 16'($urandom);
      d.right_rate = ($urandom_range(0, 3) == 0) ? d.left_rate : 16'($urandom);
      // mostly short intervals so the pose wanders instead of pinning at the limits
      d.elapsed_time = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                  : 16'($urandom_range(0, 1023));
      send_move(d, 1'b0, '0);
    end
    in_valid <= 1'b0;

    while (pending_poses.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
`default_nettype wire
